FILE: rtl/core/seeded_byte_substitution_assert.svh
// Assertion macros for the seeded byte substitution block.
// Expects clk_i and rst_ni in the scope of use.
`ifndef SEEDED_BYTE_SUBSTITUTION_ASSERT_SVH
`define SEEDED_BYTE_SUBSTITUTION_ASSERT_SVH

// same-cycle implication
`define SBS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sbs_pkg.sv
// Shared types and constants of the seeded byte substitution block.
// No dependencies.
`default_nettype none

package sbs_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'h0037_8687;
  localparam logic [WORD_W-1:0] GEN_A_INIT = 32'hf1ea_5eec;
  localparam int unsigned       WARMUP_ROUNDS = 20;
  localparam int unsigned       ROT_B = 27;
  localparam int unsigned       ROT_C = 17;

  localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INV     = 2'd2;

  typedef struct packed {
    logic load;  // reseed words
    logic step;  // advance one round
  } gen_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sbs_cfg_if.sv
// Configuration write channel carrying the seed word.
// Depends on sbs_pkg.
`default_nettype none

interface sbs_cfg_if;
  import sbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sbs_in_if.sv
// Input item channel: mode and byte.
// Depends on sbs_pkg.
`default_nettype none

interface sbs_in_if;
  import sbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sbs_out_if.sv
// Result channel: substituted byte and table status.
// Depends on sbs_pkg.
`default_nettype none

interface sbs_out_if;
  import sbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              table_ready;
  modport source (output valid, output out_byte, output table_ready, input ready);
  modport sink   (input valid, input out_byte, input table_ready, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sbs_jsf32.sv
// Four-word small fast generator, one round per cycle while step is set.
// Depends on sbs_pkg.
`default_nettype none

module sbs_jsf32 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sbs_pkg::gen_ctrl_t        ctrl_i,
  input  logic [sbs_pkg::WORD_W-1:0] seed_i,
  output logic [sbs_pkg::WORD_W-1:0] rand_o
);
  import sbs_pkg::*;

  logic [WORD_W-1:0] a_q, b_q, c_q, d_q;
  logic [WORD_W-1:0] e, a_d, b_d, c_d, d_d;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned k);
    rotl = (x << k) | (x >> (WORD_W - k));
  endfunction

  always_comb begin
    e   = a_q - rotl(b_q, ROT_B);
    a_d = b_q ^ rotl(c_q, ROT_C);
    b_d = c_q + d_q;
    c_d = d_q + e;
    d_d = e + a_d;
  end

  assign rand_o = d_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
    end else if (ctrl_i.load) begin
      a_q <= GEN_A_INIT;
      b_q <= seed_i;
      c_q <= seed_i;
      d_q <= seed_i;
    end else if (ctrl_i.step) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/seeded_byte_substitution.sv
// Seeded byte substitution: forward and inverse 256-byte tables in RAM.
// Substitute beats pass the lookup stage, then the output register; one beat
// per cycle while the output does not stall. Rebuild beat: warm-up
// rounds, fill, a swap per entry (draw and two writes), inverse pass;
// no input beat is taken meanwhile. Reset clears control state only; tables
// stay undefined until a rebuild, and bytes pass unchanged until then.
`default_nettype none
`include "seeded_byte_substitution_assert.svh"

module seeded_byte_substitution (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbs_cfg_if.sink    cfg_i,
  sbs_in_if.sink     in_i,
  sbs_out_if.source  out_o
);
  import sbs_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN, ST_DRAIN, ST_WARM, ST_FILL, ST_DRAW, ST_WR_I, ST_WR_V, ST_INV
  } state_e;

  localparam logic [CNT_W-1:0]  WARM_LAST  = CNT_W'(WARMUP_ROUNDS - 1);
  localparam logic [ADDR_W-1:0] TABLE_LAST = ADDR_W'(TABLE_DEPTH - 1);

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ADDR_W-1:0]  idx_q, v_q;
  logic               built_q;
  logic [WORD_W-1:0]  seed_q;

  logic [BYTE_W-1:0]  fwd_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0]  inv_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0]  fwd_rd_a_q, fwd_rd_b_q, inv_rd_q;

  logic               fwd_we, fwd_re, inv_we, inv_re;
  logic [ADDR_W-1:0]  fwd_wa, fwd_ra_a, fwd_ra_b, inv_wa, inv_ra;
  logic [BYTE_W-1:0]  fwd_wd, inv_wd;
  logic [CNT_W-1:0]   cnt_m1;

  logic               s1_vld_q, s1_mem_q, s1_inv_q, s1_rdy_q;
  logic [BYTE_W-1:0]  s1_byte_q, s1_result;
  logic               s1_move;
  logic               out_vld_q, out_rdy_q;
  logic [BYTE_W-1:0]  out_byte_q;

  logic               in_acc, rebuild_acc, rb_done;
  gen_ctrl_t          gen_ctrl;
  logic [WORD_W-1:0]  rand_w;

  // seed register, taken any time
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.seed;
    end
  end

  assign s1_move     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = (state_q == ST_RUN) && (!s1_vld_q || s1_move);
  assign in_acc      = in_i.valid && in_i.ready;
  assign rebuild_acc = in_acc && (in_i.mode == MODE_REBUILD);
  assign rb_done     = (state_q == ST_INV) && cnt_q[ADDR_W];

  assign gen_ctrl.load = (state_q == ST_DRAIN) && !s1_vld_q;
  assign gen_ctrl.step = (state_q == ST_WARM) || (state_q == ST_DRAW);

  sbs_jsf32 u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (seed_q),
    .rand_o (rand_w)
  );

  // rebuild sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
      idx_q   <= '0;
      v_q     <= '0;
      built_q <= 1'b0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (rebuild_acc) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          // let the pending beat leave before the RAM ports are reused
          if (!s1_vld_q) begin
            cnt_q   <= '0;
            state_q <= ST_WARM;
          end
        end
        ST_WARM: begin
          if (cnt_q == WARM_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_FILL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FILL: begin
          if (cnt_q[ADDR_W-1:0] == TABLE_LAST) begin
            idx_q   <= '0;
            state_q <= ST_DRAW;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAW: begin
          v_q     <= rand_w[ADDR_W-1:0];
          state_q <= ST_WR_I;
        end
        ST_WR_I: begin
          state_q <= ST_WR_V;
        end
        ST_WR_V: begin
          if (idx_q == TABLE_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_INV;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_DRAW;
          end
        end
        ST_INV: begin
          if (cnt_q[ADDR_W]) begin
            built_q <= 1'b1;
            state_q <= ST_RUN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign cnt_m1 = cnt_q - 1'b1;

  always_comb begin
    fwd_we   = 1'b0;
    fwd_re   = 1'b0;
    fwd_wa   = idx_q;
    fwd_wd   = fwd_rd_b_q;
    fwd_ra_a = in_i.data_byte;
    fwd_ra_b = in_i.data_byte;
    inv_we   = 1'b0;
    inv_re   = 1'b0;
    inv_wa   = fwd_rd_a_q;
    inv_wd   = cnt_m1[ADDR_W-1:0];
    inv_ra   = in_i.data_byte;
    case (state_q)
      ST_RUN: begin
        fwd_re = in_acc;
        inv_re = in_acc;
      end
      ST_FILL: begin
        fwd_we = 1'b1;
        fwd_wa = cnt_q[ADDR_W-1:0];
        fwd_wd = cnt_q[ADDR_W-1:0];
      end
      ST_DRAW: begin
        fwd_re   = 1'b1;
        fwd_ra_a = idx_q;
        fwd_ra_b = rand_w[ADDR_W-1:0];
      end
      ST_WR_I: begin
        fwd_we = 1'b1;
        fwd_wa = idx_q;
        fwd_wd = fwd_rd_b_q;
      end
      ST_WR_V: begin
        fwd_we = 1'b1;
        fwd_wa = v_q;
        fwd_wd = fwd_rd_a_q;
      end
      ST_INV: begin
        // read forward entry k, next cycle write inverse[fwd[k]] = k
        fwd_re   = !cnt_q[ADDR_W];
        fwd_ra_a = cnt_q[ADDR_W-1:0];
        inv_we   = (cnt_q != '0);
      end
      default: begin
        fwd_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (fwd_re) begin
      fwd_rd_a_q <= fwd_mem[fwd_ra_a];
      fwd_rd_b_q <= fwd_mem[fwd_ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    if (inv_re) inv_rd_q <= inv_mem[inv_ra];
  end

  // lookup stage: read data lands here in the cycle after the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_mem_q  <= 1'b0;
      s1_inv_q  <= 1'b0;
      s1_rdy_q  <= 1'b0;
      s1_byte_q <= '0;
    end else if (in_acc && (in_i.mode != MODE_REBUILD)) begin
      s1_vld_q <= 1'b1;
      s1_rdy_q <= built_q;
      case (in_i.mode)
        MODE_FWD: begin
          s1_mem_q  <= built_q;
          s1_inv_q  <= 1'b0;
          s1_byte_q <= in_i.data_byte;
        end
        MODE_INV: begin
          s1_mem_q  <= built_q;
          s1_inv_q  <= 1'b1;
          s1_byte_q <= in_i.data_byte;
        end
        default: begin
          s1_mem_q  <= 1'b0;
          s1_inv_q  <= 1'b0;
          s1_byte_q <= '0;
        end
      endcase
    end else if (rb_done) begin
      s1_vld_q  <= 1'b1;
      s1_rdy_q  <= 1'b1;
      s1_mem_q  <= 1'b0;
      s1_inv_q  <= 1'b0;
      s1_byte_q <= '0;
    end else if (s1_move) begin
      s1_vld_q <= 1'b0;
    end
  end

  assign s1_result = s1_mem_q ? (s1_inv_q ? inv_rd_q : fwd_rd_a_q) : s1_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_rdy_q  <= 1'b0;
      out_byte_q <= '0;
    end else if (s1_move) begin
      out_vld_q  <= 1'b1;
      out_rdy_q  <= s1_rdy_q;
      out_byte_q <= s1_result;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.table_ready = out_rdy_q;

  `SBS_ASSERT_NEXT(a_built_sticky, built_q, built_q, "table status dropped")
  `SBS_ASSERT_NEXT(a_rebuild_result, rb_done,
                   built_q && s1_vld_q && (state_q == ST_RUN), "rebuild beat missing")
  `SBS_ASSERT_NEXT(a_stage_hold, s1_vld_q && !s1_move, s1_vld_q, "lookup beat lost")
  `SBS_ASSERT_IMPLY(a_ports_quiet, (state_q != ST_RUN) && (state_q != ST_DRAIN),
                    !s1_vld_q && !in_i.ready, "RAM ports shared during rebuild")

endmodule

`default_nettype wire

FILE: tb/seeded_byte_substitution_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for seeded_byte_substitution: seed writes, rebuild and
// substitute beats with random idling, each result checked against a local model.
// Depends on sbs_pkg and the sbs_cfg_if, sbs_in_if and sbs_out_if interfaces.

module seeded_byte_substitution_tb;
  import sbs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned IDLE_PCT      = 32;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 12000;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 260;
  localparam int unsigned BURST_ITEMS   = 48;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              table_ready;
  } sub_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbs_cfg_if cfg_bus ();
  sbs_in_if  in_bus ();
  sbs_out_if out_bus ();

  seeded_byte_substitution dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of the block's state
  logic [WORD_W-1:0] seed_reg = SEED_RESET;
  logic [WORD_W-1:0] jsf_a, jsf_b, jsf_c, jsf_d;
  logic [BYTE_W-1:0] fwd_sbox [TABLE_DEPTH];
  logic [BYTE_W-1:0] inv_sbox [TABLE_DEPTH];
  bit                sbox_built = 1'b0;

  sub_result_t expected_results [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_gaps  = 1'b0;
  bit          sink_stalls  = 1'b0;
  bit          hold_req     = 1'b0;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  function automatic logic [WORD_W-1:0] jsf_next();
    logic [WORD_W-1:0] e;
    e     = jsf_a - rotl32(jsf_b, ROT_B);
    jsf_a = jsf_b ^ rotl32(jsf_c, ROT_C);
    jsf_b = jsf_c + jsf_d;
    jsf_c = jsf_d + e;
    jsf_d = e + jsf_a;
    return jsf_d;
  endfunction

  function automatic void rebuild_sboxes();
    logic [BYTE_W-1:0] pick;
    logic [BYTE_W-1:0] held;
    jsf_a = GEN_A_INIT;
    jsf_b = seed_reg;
    jsf_c = seed_reg;
    jsf_d = seed_reg;
    for (int i = 0; i < WARMUP_ROUNDS; i++) void'(jsf_next());
    for (int i = 0; i < TABLE_DEPTH; i++) fwd_sbox[i] = BYTE_W'(i);
    // true exchange: picking i itself leaves the entry alone
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pick           = BYTE_W'(jsf_next());
      held           = fwd_sbox[i];
      fwd_sbox[i]    = fwd_sbox[pick];
      fwd_sbox[pick] = held;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) inv_sbox[fwd_sbox[i]] = BYTE_W'(i);
    sbox_built = 1'b1;
  endfunction

  function automatic sub_result_t predict_substitution(input logic [MODE_W-1:0] mode,
                                                       input logic [BYTE_W-1:0] data);
    sub_result_t r;
    r.out_byte = '0;
    case (mode)
      MODE_REBUILD: rebuild_sboxes();
      MODE_FWD:     r.out_byte = sbox_built ? fwd_sbox[data] : data;
      MODE_INV:     r.out_byte = sbox_built ? inv_sbox[data] : data;
      default:      r.out_byte = '0;
    endcase
    r.table_ready = sbox_built;
    return r;
  endfunction

  // valid stays high between back-to-back beats; dropped only for a gap
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data);
    while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= mode;
    in_bus.data_byte <= data;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    expected_results.push_back(predict_substitution(mode, data));
  endtask

  // seed only changes with the pipe empty
  task automatic write_seed(input logic [WORD_W-1:0] value);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.seed  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    seed_reg = value;
  endtask

  task automatic test_passthrough_before_build();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_item(MODE_FWD, 8'h00);
    send_item(MODE_FWD, 8'hff);
    send_item(MODE_INV, 8'ha5);
    send_item(MODE_INV, 8'h5a);
    send_item(MODE_UNUSED, 8'h3c);
  endtask

  task automatic test_first_build();
    send_item(MODE_REBUILD, 8'h00);
    send_item(MODE_FWD, 8'h00);
    send_item(MODE_FWD, 8'hff);
    send_item(MODE_INV, 8'h00);
    send_item(MODE_INV, 8'hff);
    send_item(MODE_UNUSED, 8'hff);
  endtask

  task automatic test_seed_extremes();
    write_seed('0);
    send_item(MODE_REBUILD, 8'hff);
    send_item(MODE_FWD, 8'h80);
    send_item(MODE_INV, 8'h7f);
    write_seed('1);
    send_item(MODE_REBUILD, 8'h55);
    send_item(MODE_FWD, 8'h01);
    send_item(MODE_INV, 8'hfe);
    // same seed again must give the same tables
    send_item(MODE_REBUILD, 8'haa);
    send_item(MODE_FWD, 8'h01);
    send_item(MODE_INV, 8'hfe);
  endtask

  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_req    = 1'b1;
    for (int n = 0; n < BURST_ITEMS; n++)
      send_item(n[0] ? MODE_FWD : MODE_INV, BYTE_W'($urandom()));
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // first phase runs without any idling
      sender_gaps = (p != 0);
      sink_stalls = (p != 0);
      write_seed($urandom());
      send_item(MODE_REBUILD, BYTE_W'($urandom()));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(199);
        if (pick < 3)
          send_item(MODE_REBUILD, BYTE_W'($urandom()));
        else if (pick < 7)
          send_item(MODE_UNUSED, BYTE_W'($urandom()));
        else
          send_item(pick[0] ? MODE_FWD : MODE_INV, BYTE_W'($urandom()));
      end
    end
  endtask

  initial begin : sink_ready_gen
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(sink_stalls && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sub_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: out_byte %0h table_ready %0b",
               out_bus.out_byte, out_bus.table_ready);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, out_bus.out_byte);
          error_count++;
        end
        if (out_bus.table_ready !== want.table_ready) begin
          $error("table_ready: expected %0b, actual %0b",
                 want.table_ready, out_bus.table_ready);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : stall_watch
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("seeded_byte_substitution regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.mode      <= MODE_FWD;
    in_bus.data_byte <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.seed     <= SEED_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_before_build();
    test_first_build();
    test_seed_extremes();
    test_output_backpressure();
    test_random_traffic();

    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("seeded_byte_substitution regression: pass");
    else
      $display("seeded_byte_substitution regression: fail");
    $finish;
  end

endmodule
